/* src/slel_pkg.sv */
// Shared types and constants of the search line edge locator.
`default_nettype none

package slel_pkg;

  // Line and window geometry.
  localparam int unsigned MaxLineLen = 64;
  localparam int unsigned WinLen     = 7;
  localparam int unsigned PosW       = $clog2(MaxLineLen + 1);
  localparam int unsigned IdxW       = 6;

  // Number formats: Q0.16 samples, Q0.24 triple products, Q0.48 likelihoods.
  localparam int unsigned ProbW = 16;
  localparam int unsigned TriW  = 24;
  localparam int unsigned LikW  = 48;

  // Shared multiplier of the back end.
  localparam int unsigned MulAW = 32;
  localparam int unsigned MulBW = 24;
  localparam int unsigned MulPW = MulAW + MulBW;

  // Sequencer steps of one centre test.
  localparam int unsigned StepW    = 4;
  localparam int unsigned LastStep = 10;

  // Queue between the front and the back end.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  // Configuration register map.
  localparam int unsigned        PaddrW           = 2;
  localparam int unsigned        PdataW           = 32;
  localparam logic [PaddrW-1:0]  RegEdgeThreshold = '0;
  localparam logic [ProbW-1:0]   ThresholdReset   = 16'h8000;

  typedef struct packed {
    logic [ProbW-1:0] fg_prob;
    logic [ProbW-1:0] bg_prob;
    logic             last_sample;
  } in_item_t;

  typedef struct packed {
    logic             edge_found;
    logic [IdxW-1:0]  edge_index;
    logic [LikW-1:0]  edge_score;
  } out_item_t;

  // One job for the back end: an optional centre test and an optional line end.
  typedef struct packed {
    logic                  do_test;
    logic                  line_end;
    logic [IdxW-1:0]       center;
    logic [2:0][ProbW-1:0] fg_behind;
    logic [2:0][ProbW-1:0] bg_behind;
    logic [2:0][ProbW-1:0] fg_ahead;
    logic [2:0][ProbW-1:0] bg_ahead;
  } task_t;

  typedef enum logic [1:0] {
    BkIdle,
    BkMult,
    BkDecide,
    BkReport
  } back_state_e;

endpackage

`default_nettype wire

/* src/slel_front.sv */
// Front end: sample window, position count and edge step test.
`default_nettype none

module slel_front (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          accept_i,
  input  wire slel_pkg::in_item_t      in_item_i,
  input  wire [slel_pkg::ProbW-1:0]    threshold_i,
  output logic                         task_push_o,
  output slel_pkg::task_t              task_o
);

  logic [slel_pkg::WinLen-1:0][slel_pkg::ProbW-1:0] fg_win_q, fg_win_d;
  logic [slel_pkg::WinLen-1:0][slel_pkg::ProbW-1:0] bg_win_q, bg_win_d;
  logic [slel_pkg::PosW-1:0]  pos_q, pos_d;
  logic [slel_pkg::ProbW-1:0] step;
  logic                       in_range;

  // Window as it stands once this beat has been shifted in.
  always_comb begin
    fg_win_d = {in_item_i.fg_prob, fg_win_q[slel_pkg::WinLen-1:1]};
    bg_win_d = {in_item_i.bg_prob, bg_win_q[slel_pkg::WinLen-1:1]};
  end

  assign step = (fg_win_d[4] > fg_win_d[2]) ? fg_win_d[4] - fg_win_d[2]
                                             : fg_win_d[2] - fg_win_d[4];

  assign in_range = (pos_q >= slel_pkg::PosW'(slel_pkg::WinLen - 1)) &&
                    (pos_q <  slel_pkg::PosW'(slel_pkg::MaxLineLen));

  always_comb begin
    pos_d = pos_q;
    if (pos_q < slel_pkg::PosW'(slel_pkg::MaxLineLen)) begin
      pos_d = pos_q + 1'b1;
    end
  end

  always_comb begin
    task_o.do_test   = in_range && (step > threshold_i);
    task_o.line_end  = in_item_i.last_sample;
    task_o.center    = slel_pkg::IdxW'(pos_q - slel_pkg::PosW'(3));
    task_o.fg_behind = fg_win_d[2:0];
    task_o.bg_behind = bg_win_d[2:0];
    task_o.fg_ahead  = fg_win_d[6:4];
    task_o.bg_ahead  = bg_win_d[6:4];
  end

  assign task_push_o = accept_i && (task_o.do_test || task_o.line_end);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_win_q <= '0;
      bg_win_q <= '0;
      pos_q    <= '0;
    end else if (accept_i) begin
      if (in_item_i.last_sample) begin
        fg_win_q <= '0;
        bg_win_q <= '0;
        pos_q    <= '0;
      end else begin
        fg_win_q <= fg_win_d;
        bg_win_q <= bg_win_d;
        pos_q    <= pos_d;
      end
    end
  end

endmodule

`default_nettype wire

/* src/slel_queue.sv */
// Short job queue between the front end and the back end.
`default_nettype none

module slel_queue (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    push_i,
  input  wire slel_pkg::task_t   task_i,
  input  wire                    pop_i,
  output logic                   full_o,
  output logic                   empty_o,
  output slel_pkg::task_t        head_o
);

  slel_pkg::task_t            entry_q [slel_pkg::QDepth];
  logic [slel_pkg::QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [slel_pkg::QPtrW:0]   count_q;

  assign full_o  = (count_q == (slel_pkg::QPtrW+1)'(slel_pkg::QDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= task_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* src/slel_back.sv */
// Back end: likelihood sequencer, best centre tracking and result register.
`default_nettype none

module slel_back (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    q_empty_i,
  input  wire slel_pkg::task_t   head_i,
  output logic                   q_pop_o,
  input  wire                    pop_i,
  output logic                   empty_o,
  output slel_pkg::out_item_t    out_item_o
);

  slel_pkg::back_state_e state_q, state_d;
  logic [slel_pkg::StepW-1:0] step_q, step_d;

  logic [slel_pkg::MulAW-1:0] op_a;
  logic [slel_pkg::MulBW-1:0] op_b;
  logic [slel_pkg::MulPW-1:0] prod;

  logic [slel_pkg::MulAW-1:0] tmp_q;
  logic [slel_pkg::TriW-1:0]  bf_q, bb_q, ff_q, fb_q;
  logic [slel_pkg::LikW-1:0]  lc_q, lf_q, lb_q;

  logic                       best_valid_q;
  logic [slel_pkg::LikW-1:0]  best_lik_q;
  logic [slel_pkg::IdxW-1:0]  best_pos_q;

  logic                       out_valid_q;
  slel_pkg::out_item_t        out_q;

  logic candidate, better, update_best, load_out, out_free;

  // Operand selection for the one shared multiplier.
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (step_q)
      4'd0: begin
        op_a = slel_pkg::MulAW'(head_i.fg_behind[0]);
        op_b = slel_pkg::MulBW'(head_i.fg_behind[1]);
      end
      4'd1: begin
        op_a = tmp_q;
        op_b = slel_pkg::MulBW'(head_i.fg_behind[2]);
      end
      4'd2: begin
        op_a = slel_pkg::MulAW'(head_i.bg_behind[0]);
        op_b = slel_pkg::MulBW'(head_i.bg_behind[1]);
      end
      4'd3: begin
        op_a = tmp_q;
        op_b = slel_pkg::MulBW'(head_i.bg_behind[2]);
      end
      4'd4: begin
        op_a = slel_pkg::MulAW'(head_i.fg_ahead[0]);
        op_b = slel_pkg::MulBW'(head_i.fg_ahead[1]);
      end
      4'd5: begin
        op_a = tmp_q;
        op_b = slel_pkg::MulBW'(head_i.fg_ahead[2]);
      end
      4'd6: begin
        op_a = slel_pkg::MulAW'(head_i.bg_ahead[0]);
        op_b = slel_pkg::MulBW'(head_i.bg_ahead[1]);
      end
      4'd7: begin
        op_a = tmp_q;
        op_b = slel_pkg::MulBW'(head_i.bg_ahead[2]);
      end
      4'd8: begin
        op_a = slel_pkg::MulAW'(bb_q);
        op_b = ff_q;
      end
      4'd9: begin
        op_a = slel_pkg::MulAW'(bf_q);
        op_b = ff_q;
      end
      4'd10: begin
        op_a = slel_pkg::MulAW'(bb_q);
        op_b = fb_q;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod = slel_pkg::MulPW'(op_a) * slel_pkg::MulPW'(op_b);

  // Every step registers its product; odd steps below eight keep the Q0.24 part.
  always_ff @(posedge clk_i) begin
    if (state_q == slel_pkg::BkMult) begin
      case (step_q)
        4'd0, 4'd2, 4'd4, 4'd6: tmp_q <= prod[slel_pkg::MulAW-1:0];
        4'd1:  bf_q <= prod[47:24];
        4'd3:  bb_q <= prod[47:24];
        4'd5:  ff_q <= prod[47:24];
        4'd7:  fb_q <= prod[47:24];
        4'd8:  lc_q <= prod[slel_pkg::LikW-1:0];
        4'd9:  lf_q <= prod[slel_pkg::LikW-1:0];
        4'd10: lb_q <= prod[slel_pkg::LikW-1:0];
        default: tmp_q <= tmp_q;
      endcase
    end
  end

  assign candidate   = (lc_q > lf_q) && (lc_q > lb_q);
  assign better      = !best_valid_q || (lc_q > best_lik_q);
  assign update_best = (state_q == slel_pkg::BkDecide) && candidate && better;
  assign out_free    = !out_valid_q || pop_i;

  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    q_pop_o  = 1'b0;
    load_out = 1'b0;
    case (state_q)
      slel_pkg::BkIdle: begin
        step_d = '0;
        if (!q_empty_i) begin
          state_d = head_i.do_test ? slel_pkg::BkMult : slel_pkg::BkReport;
        end
      end
      slel_pkg::BkMult: begin
        step_d = step_q + 1'b1;
        if (step_q == slel_pkg::StepW'(slel_pkg::LastStep)) begin
          state_d = slel_pkg::BkDecide;
        end
      end
      slel_pkg::BkDecide: begin
        if (head_i.line_end) begin
          state_d = slel_pkg::BkReport;
        end else begin
          q_pop_o = 1'b1;
          state_d = slel_pkg::BkIdle;
        end
      end
      slel_pkg::BkReport: begin
        if (out_free) begin
          load_out = 1'b1;
          q_pop_o  = 1'b1;
          state_d  = slel_pkg::BkIdle;
        end
      end
      default: state_d = slel_pkg::BkIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= slel_pkg::BkIdle;
      step_q       <= '0;
      best_valid_q <= 1'b0;
      best_lik_q   <= '0;
      best_pos_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (load_out) begin
        best_valid_q <= 1'b0;
        best_lik_q   <= '0;
        best_pos_q   <= '0;
      end else if (update_best) begin
        best_valid_q <= 1'b1;
        best_lik_q   <= lc_q;
        best_pos_q   <= head_i.center;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q.edge_found <= best_valid_q;
      out_q.edge_index <= best_pos_q;
      out_q.edge_score <= best_lik_q;
    end
  end

  assign empty_o    = !out_valid_q;
  assign out_item_o = out_q;

  // A job leaves the queue only once its test or its report is finished.
  a_pop_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (state_q == slel_pkg::BkDecide) || (state_q == slel_pkg::BkReport))
    else $error("job popped outside decide or report");

  // With no best centre held, the tracking registers stay cleared.
  a_best_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !best_valid_q |-> (best_lik_q == '0) && (best_pos_q == '0))
    else $error("best centre registers hold stale data");

  // A report waits while an unread result still occupies the output register.
  a_report_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == slel_pkg::BkReport) && out_valid_q && !pop_i
      |=> (state_q == slel_pkg::BkReport) && out_valid_q)
    else $error("report overwrote an unread result");

  // The step counter only runs while multiplying.
  a_step_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == slel_pkg::BkDecide) |-> $past(step_q) == slel_pkg::StepW'(slel_pkg::LastStep))
    else $error("decide entered before the last multiply step");

endmodule

`default_nettype wire

/* src/search_line_edge_locator.sv */
// Top level of the search line edge locator: register port, front, queue and back.
//
// Usage: probability pairs for one search line are pushed one beat per position
// (push/full); the beat with last_sample set closes the line. For every line the
// block delivers exactly one result beat on the output queue (empty/pop): the
// first centre with the largest contour likelihood, or edge_found low.
// Throughput: the front end takes one beat per cycle while the job queue has room.
// A beat that neither opens a centre test nor ends the line costs the back end
// nothing; a centre that passes the edge step test takes the back end through idle,
// eleven steps of the single shared 32 x 24 multiplier and decide. A line end adds
// a report state after a tested centre, or alone passes through idle and report.
// A four-entry job queue absorbs bursts; full rises once all four entries hold jobs,
// so the sustained rate is set by how many centres pass the step test.
// With the queue empty, the last beat's job passes idle, the multiply steps, decide
// and report if it completes a tested centre, else idle and report; empty then falls.
// The edge threshold is written over the APB-style port at byte address 0 and
// must only change while no line is in flight. Reset clears the window, the
// position count, the queue, the best centre and the result valid flag, and sets
// the threshold to one half. While the receiver leaves a result unread, the next
// line end waits in the back end, the queue fills and full stalls the sender.
`default_nettype none

module search_line_edge_locator (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // Input queue side.
  input  wire                              push,
  output logic                             full,
  input  wire slel_pkg::in_item_t          in_item_i,
  // Result queue side.
  output logic                             empty,
  input  wire                              pop,
  output slel_pkg::out_item_t              out_item_o,
  // Configuration port.
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire [slel_pkg::PaddrW-1:0]       paddr,
  input  wire [slel_pkg::PdataW-1:0]       pwdata,
  output logic [slel_pkg::PdataW-1:0]      prdata,
  output logic                             pready
);

  logic [slel_pkg::ProbW-1:0] threshold_q;
  logic                       accept;
  logic                       task_push;
  slel_pkg::task_t            task_in;
  slel_pkg::task_t            head;
  logic                       q_full, q_empty, q_pop;
  logic                       cfg_write;

  // The port never inserts wait states.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr == slel_pkg::RegEdgeThreshold);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= slel_pkg::ThresholdReset;
    end else if (cfg_write) begin
      threshold_q <= pwdata[slel_pkg::ProbW-1:0];
    end
  end

  assign prdata = (paddr == slel_pkg::RegEdgeThreshold) ?
                  slel_pkg::PdataW'(threshold_q) : '0;

  // A beat is taken whenever the job queue has room, even if this beat makes no job.
  assign full   = q_full;
  assign accept = push && !q_full;

  slel_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_item_i   (in_item_i),
    .threshold_i (threshold_q),
    .task_push_o (task_push),
    .task_o      (task_in)
  );

  slel_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (task_push),
    .task_i  (task_in),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (head)
  );

  slel_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .head_i     (head),
    .q_pop_o    (q_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_item_o (out_item_o)
  );

endmodule

`default_nettype wire

/* tb/slel_edge_checker.sv */
// Checker that predicts the edge report of every search line and compares the result beats.
module slel_edge_checker
  import slel_pkg::*;
(
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  wire              full_i,
  input  wire in_item_t    in_item_i,
  input  wire              empty_i,
  input  wire              pop_i,
  input  wire out_item_t   out_item_i,
  input  wire              psel_i,
  input  wire              penable_i,
  input  wire              pwrite_i,
  input  wire              pready_i,
  input  wire [PaddrW-1:0] paddr_i,
  input  wire [PdataW-1:0] pwdata_i,
  output int unsigned      errors_o,
  output int unsigned      pending_o
);

  logic [ProbW-1:0] fg_win [WinLen];
  logic [ProbW-1:0] bg_win [WinLen];
  logic [PosW-1:0]  line_pos;
  logic [LikW-1:0]  best_score;
  logic [IdxW-1:0]  best_index;
  logic             best_valid;
  logic [ProbW-1:0] threshold;
  out_item_t        expected_reports [$];
  out_item_t        want;
  int unsigned      err_count;

  function automatic logic [TriW-1:0] triple_q24(input logic [ProbW-1:0] a,
                                                 input logic [ProbW-1:0] b,
                                                 input logic [ProbW-1:0] c);
    logic [LikW-1:0] prod;
    prod = LikW'(a) * LikW'(b) * LikW'(c);
    return prod[LikW-1:TriW];
  endfunction

  function automatic void clear_line();
    for (int i = 0; i < WinLen; i++) begin
      fg_win[i] = '0;
      bg_win[i] = '0;
    end
    line_pos   = '0;
    best_score = '0;
    best_index = '0;
    best_valid = 1'b0;
  endfunction

  // Window slot 3 is the centre, slots 0..2 lie behind it and 4..6 in front.
  function automatic void score_center(input logic [IdxW-1:0] center);
    logic [ProbW-1:0] step;
    logic [TriW-1:0]  fg_behind, bg_behind, fg_ahead, bg_ahead;
    logic [LikW-1:0]  contour, fore, back;
    step = (fg_win[4] > fg_win[2]) ? fg_win[4] - fg_win[2] : fg_win[2] - fg_win[4];
    if (step <= threshold) return;
    fg_behind = triple_q24(fg_win[0], fg_win[1], fg_win[2]);
    bg_behind = triple_q24(bg_win[0], bg_win[1], bg_win[2]);
    fg_ahead  = triple_q24(fg_win[4], fg_win[5], fg_win[6]);
    bg_ahead  = triple_q24(bg_win[4], bg_win[5], bg_win[6]);
    contour   = LikW'(bg_behind) * LikW'(fg_ahead);
    fore      = LikW'(fg_behind) * LikW'(fg_ahead);
    back      = LikW'(bg_behind) * LikW'(bg_ahead);
    // Ties keep the earlier centre.
    if (contour > fore && contour > back && (!best_valid || contour > best_score)) begin
      best_valid = 1'b1;
      best_score = contour;
      best_index = center;
    end
  endfunction

  function automatic void take_sample(input in_item_t beat);
    out_item_t report;
    for (int i = 0; i < WinLen - 1; i++) begin
      fg_win[i] = fg_win[i+1];
      bg_win[i] = bg_win[i+1];
    end
    fg_win[WinLen-1] = beat.fg_prob;
    bg_win[WinLen-1] = beat.bg_prob;
    if (line_pos >= WinLen - 1 && line_pos < MaxLineLen) score_center(IdxW'(line_pos - 3));
    if (line_pos < MaxLineLen) line_pos++;
    if (beat.last_sample) begin
      report = '0;
      if (best_valid) begin
        report.edge_found = 1'b1;
        report.edge_index = best_index;
        report.edge_score = best_score;
      end
      expected_reports.insert(expected_reports.size(), report);
      clear_line();
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold = ThresholdReset;
      clear_line();
      expected_reports.delete();
      err_count = 0;
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == RegEdgeThreshold) begin
        threshold = pwdata_i[ProbW-1:0];
      end
      if (push_i && !full_i) take_sample(in_item_i);
      if (pop_i && !empty_i) begin
        if (expected_reports.size() == 0) begin
          $error("result beat with no line end waiting: %p", out_item_i);
          err_count++;
        end else begin
          want = expected_reports.pop_front();
          if (out_item_i.edge_found !== want.edge_found) begin
            $error("edge_found: expected %0d, got %0d", want.edge_found, out_item_i.edge_found);
            err_count++;
          end
          if (out_item_i.edge_index !== want.edge_index) begin
            $error("edge_index: expected %0d, got %0d", want.edge_index, out_item_i.edge_index);
            err_count++;
          end
          if (out_item_i.edge_score !== want.edge_score) begin
            $error("edge_score: expected %h, got %h", want.edge_score, out_item_i.edge_score);
            err_count++;
          end
        end
      end
      errors_o  <= err_count;
      pending_o <= expected_reports.size();
    end
  end

endmodule

/* tb/tb_search_line_edge_locator.sv */
// Testbench top of the search line edge locator: clock, reset, stimulus and verdict.
module tb_search_line_edge_locator;
  import slel_pkg::*;

  // How the samples of one random search line are drawn.
  typedef enum logic [1:0] {
    LineNoise,
    LineStep,
    LineExtreme
  } line_shape_e;

  localparam int unsigned SegmentBeats = 160;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned LimitCycles  = 400000;

  logic             clk_i;
  logic             rst_ni      = 1'b0;
  logic             push        = 1'b0;
  in_item_t         sample_beat = '0;
  logic             pop         = 1'b0;
  logic             psel        = 1'b0;
  logic             penable     = 1'b0;
  logic             pwrite      = 1'b0;
  logic [PaddrW-1:0] paddr      = '0;
  logic [PdataW-1:0] pwdata     = '0;
  logic             full;
  logic             empty;
  logic             pready;
  logic [PdataW-1:0] prdata;
  out_item_t        report_beat;
  int unsigned      errors;
  int unsigned      pending;
  int unsigned      send_idle_pct = 26;
  int unsigned      recv_idle_pct = 46;
  int unsigned      beats_sent    = 0;

  search_line_edge_locator u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (sample_beat),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (report_beat),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // The checker sees every beat on both queues and every register write, and keeps
  // its own copy of the threshold and of the line state.
  slel_edge_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_i     (full),
    .in_item_i  (sample_beat),
    .empty_i    (empty),
    .pop_i      (pop),
    .out_item_i (report_beat),
    .psel_i     (psel),
    .penable_i  (penable),
    .pwrite_i   (pwrite),
    .pready_i   (pready),
    .paddr_i    (paddr),
    .pwdata_i   (pwdata),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // The receiver stalls at random; the rate is changed by the stimulus between phases.
  always @(posedge clk_i) begin
    pop <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Offers one beat after a random number of idle cycles and returns once it has been
  // taken. push is left high so that a following beat can go out on the next edge.
  task automatic send_beat(input logic [ProbW-1:0] fg, input logic [ProbW-1:0] bg,
                           input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push        <= 1'b1;
    sample_beat <= '{fg_prob: fg, bg_prob: bg, last_sample: last};
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    beats_sent++;
  endtask

  // Holds the sender back until every expected report has been taken. The report count
  // in the checker is registered, hence the sender waits before looking at it.
  // The settling time afterwards covers beats of the line end still inside the block.
  task automatic wait_drained();
    push <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Setup cycle, then access cycle; the register takes the value once pready is seen.
  task automatic write_threshold(input logic [ProbW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RegEdgeThreshold;
    pwdata  <= PdataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Mostly the rails and their neighbours, so that products saturate or vanish.
  function automatic logic [ProbW-1:0] extreme_value();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return 16'h0001;
      3:       return 16'hFFFE;
      default: return ProbW'($urandom_range(0, 65535));
    endcase
  endfunction

  // A step line has a foreground that jumps from a low band to a high band (or back,
  // for a falling edge) at a random position, with the background doing the opposite,
  // which is the pattern that makes a centre a candidate. Now and then a sample is pure
  // noise, so that neighbouring centres compete with one another.
  task automatic send_line(input int unsigned len, input line_shape_e shape);
    int unsigned      edge_at;
    logic             falling;
    logic             ahead;
    logic [ProbW-1:0] low_cap;
    logic [ProbW-1:0] high_floor;
    logic [ProbW-1:0] fg;
    logic [ProbW-1:0] bg;
    edge_at    = $urandom_range(0, len - 1);
    falling    = $urandom_range(0, 3) == 0;
    low_cap    = ProbW'($urandom_range(0, 16'h3FFF));
    high_floor = ProbW'($urandom_range(16'hB000, 16'hFFFF));
    for (int p = 0; p < len; p++) begin
      ahead = (p >= edge_at) ^ falling;
      case (shape)
        LineStep: begin
          if ($urandom_range(0, 15) == 0) begin
            fg = ProbW'($urandom_range(0, 65535));
            bg = ProbW'($urandom_range(0, 65535));
          end else if (ahead) begin
            fg = ProbW'($urandom_range(high_floor, 16'hFFFF));
            bg = ProbW'($urandom_range(0, low_cap));
          end else begin
            fg = ProbW'($urandom_range(0, low_cap));
            bg = ProbW'($urandom_range(high_floor, 16'hFFFF));
          end
        end
        LineExtreme: begin
          fg = extreme_value();
          bg = extreme_value();
        end
        default: begin
          fg = ProbW'($urandom_range(0, 65535));
          bg = ProbW'($urandom_range(0, 65535));
        end
      endcase
      send_beat(fg, bg, p == len - 1);
    end
  endtask

  initial begin
    logic [ProbW-1:0] seg_threshold [6];
    int unsigned      line_len;
    int unsigned      seg_end;
    line_shape_e      shape;
    // Each random segment runs under its own threshold, the extremes among them.
    // A threshold of all ones lets no centre through, zero lets nearly all through.
    seg_threshold    = '{16'h0000, 16'h2000, 16'hFFFF, 16'h0000, 16'h7FFF, 16'h1000};
    seg_threshold[3] = ProbW'($urandom_range(0, 65535));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed lines under the reset threshold of one half.
    // A line of a single beat, which has no centre at all.
    send_beat(16'hFFFF, 16'hFFFF, 1'b1);
    // The longest line that is still too short to hold a centre.
    for (int p = 0; p < WinLen - 1; p++) begin
      send_beat(ProbW'($urandom_range(0, 65535)), ProbW'($urandom_range(0, 65535)),
                p == WinLen - 2);
    end
    // A falling foreground edge: the step test passes, but the contour likelihood is
    // zero and cannot beat the others, so nothing is found.
    for (int p = 0; p < WinLen; p++) begin
      send_beat(p < 4 ? 16'hFFFF : 16'h0000, p < 4 ? 16'h0000 : 16'hFFFF, p == WinLen - 1);
    end
    // A rising edge over eight beats: centres 3 and 4 have the same contour
    // likelihood, and the earlier one must be reported.
    for (int p = 0; p < 8; p++) begin
      send_beat(p < 4 ? 16'h0000 : 16'hFFFF, p < 4 ? 16'hFFFF : 16'h0000, p == 7);
    end

    // Random lines in six segments. The first two keep the sender idling less than the
    // receiver, the middle two swap the rates, the last two run without idling. Every
    // segment starts from a drained block, which is when the threshold may change.
    for (int seg = 0; seg < 6; seg++) begin
      wait_drained();
      if (seg == 2) begin
        send_idle_pct = 46;
        recv_idle_pct = 26;
      end
      if (seg == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_threshold(seg_threshold[seg]);
      seg_end = beats_sent + SegmentBeats;
      while (beats_sent < seg_end) begin
        // Most lines hold one to 34 centres; some are too short for one, some
        // fill the line exactly and some overrun it, so that the count saturates.
        case ($urandom_range(0, 19))
          0:       line_len = $urandom_range(1, WinLen - 1);
          1:       line_len = $urandom_range(MaxLineLen + 1, MaxLineLen + 8);
          2:       line_len = MaxLineLen;
          default: line_len = $urandom_range(WinLen, 40);
        endcase
        case ($urandom_range(0, 9))
          0, 1:    shape = LineNoise;
          2, 3:    shape = LineExtreme;
          default: shape = LineStep;
        endcase
        send_line(line_len, shape);
      end
    end

    wait_drained();
    if (errors == 0) begin
      $display("search_line_edge_locator: match");
    end else begin
      $display("search_line_edge_locator: mismatch");
    end
    $finish;
  end

  // Ends a run that hangs, for instance when a report never arrives.
  initial begin
    #(LimitCycles * 20);
    $display("search_line_edge_locator: mismatch");
    $finish;
  end

endmodule

/* sim.f */
src/slel_pkg.sv
src/slel_front.sv
src/slel_queue.sv
src/slel_back.sv
src/search_line_edge_locator.sv
tb/slel_edge_checker.sv
tb/tb_search_line_edge_locator.sv
